FILE: rtl/owb_pkg.sv
`timescale 1ns / 1ps

package owb_pkg;

    localparam int unsigned CountW = 10;
    localparam int unsigned SlotW  = 8;
    localparam int unsigned IndexW = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [IndexW-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_SLOT_LOW      = 3'd3,
        REG_SAMPLE_WAIT   = 3'd4,
        REG_SLOT_TAIL     = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LOW  = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_TAIL = 4'b1000
    } phase_t;

    localparam logic [CountW-1:0] RESET_LOW_INIT     = 10'd480;
    localparam logic [CountW-1:0] PRESENCE_WAIT_INIT = 10'd66;
    localparam logic [CountW-1:0] RESET_TAIL_INIT    = 10'd414;
    localparam logic [SlotW-1:0]  SLOT_LOW_INIT      = 8'd1;
    localparam logic [SlotW-1:0]  SAMPLE_WAIT_INIT   = 8'd14;
    localparam logic [SlotW-1:0]  SLOT_TAIL_INIT     = 8'd45;

    localparam logic [7:0] READ_PATTERN = 8'hFF;
    localparam logic [2:0] LAST_BIT     = 3'd7;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       line_level;
    } owb_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
    } owb_out_t;

    typedef struct packed {
        logic [CountW-1:0] reset_low_ticks;
        logic [CountW-1:0] presence_wait_ticks;
        logic [CountW-1:0] reset_tail_ticks;
        logic [SlotW-1:0]  slot_low_ticks;
        logic [SlotW-1:0]  sample_wait_ticks;
        logic [SlotW-1:0]  slot_tail_ticks;
    } owb_cfg_t;

    function automatic logic [CountW-1:0] load_count(input logic [CountW-1:0] n);
        load_count = (n == '0) ? '0 : n - 10'd1;
    endfunction

endpackage

FILE: rtl/owb_core.sv
`timescale 1ns / 1ps

module owb_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  owb_pkg::owb_cfg_t cfg,
    input  owb_pkg::owb_in_t  item,
    output owb_pkg::owb_out_t res
);

    owb_pkg::phase_t             phase_reg, phase_next;
    logic [owb_pkg::CountW-1:0]  tick_count_reg, tick_count_next;
    logic [2:0]                  bit_index_reg, bit_index_next;
    logic [7:0]                  shift_byte_reg, shift_byte_next;
    logic                        presence_reg, presence_next;
    logic                        slot_bit_reg, slot_bit_next;
    logic                        is_reset_reg, is_reset_next;
    logic [7:0]                  rx_hold_reg, rx_hold_next;

    logic                        end_now;
    logic                        end_bit;
    logic                        done_now;
    logic [owb_pkg::CountW-1:0]  tail;
    logic [7:0]                  shifted;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        presence_next   = presence_reg;
        slot_bit_next   = slot_bit_reg;
        is_reset_next   = is_reset_reg;
        rx_hold_next    = rx_hold_reg;
        end_now         = 1'b0;
        end_bit         = slot_bit_reg;
        done_now        = 1'b0;
        tail            = '0;
        shifted         = '0;

        unique case (phase_reg)
            owb_pkg::PH_IDLE:
            begin
                case (item.command) inside
                    owb_pkg::CMD_RESET:
                    begin
                        is_reset_next   = 1'b1;
                        phase_next      = owb_pkg::PH_LOW;
                        tick_count_next = owb_pkg::load_count(cfg.reset_low_ticks);
                    end
                    owb_pkg::CMD_WRITE, owb_pkg::CMD_READ:
                    begin
                        is_reset_next   = 1'b0;
                        shift_byte_next = (item.command == owb_pkg::CMD_WRITE)
                                          ? item.tx_byte : owb_pkg::READ_PATTERN;
                        bit_index_next  = '0;
                        slot_bit_next   = 1'b0;
                        phase_next      = owb_pkg::PH_LOW;
                        tick_count_next = owb_pkg::load_count(
                                              {2'b00, cfg.slot_low_ticks});
                    end
                    default:
                    begin
                    end
                endcase
            end
            owb_pkg::PH_LOW:
            begin
                if (tick_count_reg == '0)
                begin
                    phase_next      = owb_pkg::PH_WAIT;
                    tick_count_next = owb_pkg::load_count(is_reset_reg
                                          ? cfg.presence_wait_ticks
                                          : {2'b00, cfg.sample_wait_ticks});
                end
                else
                begin
                    tick_count_next = tick_count_reg - 10'd1;
                end
            end
            owb_pkg::PH_WAIT:
            begin
                if (tick_count_reg == '0)
                begin
                    if (is_reset_reg)
                    begin
                        presence_next = ~item.line_level;
                        tail          = cfg.reset_tail_ticks;
                    end
                    else
                    begin
                        end_bit       = shift_byte_reg[0] & item.line_level;
                        slot_bit_next = end_bit;
                        tail          = {2'b00, cfg.slot_tail_ticks};
                    end
                    if (tail == '0)
                    begin
                        end_now = 1'b1;
                    end
                    else
                    begin
                        phase_next      = owb_pkg::PH_TAIL;
                        tick_count_next = tail - 10'd1;
                    end
                end
                else
                begin
                    tick_count_next = tick_count_reg - 10'd1;
                end
            end
            owb_pkg::PH_TAIL:
            begin
                if (tick_count_reg == '0)
                begin
                    end_now = 1'b1;
                end
                else
                begin
                    tick_count_next = tick_count_reg - 10'd1;
                end
            end
            default:
            begin
                phase_next = owb_pkg::PH_IDLE;
            end
        endcase

        if (end_now)
        begin
            if (is_reset_reg)
            begin
                phase_next = owb_pkg::PH_IDLE;
                done_now   = 1'b1;
            end
            else
            begin
                shifted         = {end_bit, shift_byte_reg[7:1]};
                shift_byte_next = shifted;
                if (bit_index_reg == owb_pkg::LAST_BIT)
                begin
                    rx_hold_next   = shifted;
                    bit_index_next = '0;
                    phase_next     = owb_pkg::PH_IDLE;
                    done_now       = 1'b1;
                end
                else
                begin
                    bit_index_next  = bit_index_reg + 3'd1;
                    phase_next      = owb_pkg::PH_LOW;
                    tick_count_next = owb_pkg::load_count({2'b00, cfg.slot_low_ticks});
                end
            end
        end
    end

    always_comb
    begin
        if (phase_next == owb_pkg::PH_LOW)
            res.drive_low = 1'b1;
        else if (phase_next == owb_pkg::PH_IDLE || is_reset_next)
            res.drive_low = 1'b0;
        else
            res.drive_low = ~shift_byte_next[0];
        res.busy_res = (phase_next != owb_pkg::PH_IDLE);
        res.done_res = done_now;
        res.presence = presence_next;
        res.rx_byte  = rx_hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= owb_pkg::PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            presence_reg   <= 1'b0;
            slot_bit_reg   <= 1'b0;
            is_reset_reg   <= 1'b0;
            rx_hold_reg    <= '0;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            presence_reg   <= presence_next;
            slot_bit_reg   <= slot_bit_next;
            is_reset_reg   <= is_reset_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

`ifndef SYNTHESIS
    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        en && res.done_res |-> !res.busy_res && !res.drive_low)
        else $error("done beat while busy or driving");

    a_idle_tick_stays: assert property (@(posedge clk) disable iff (!rst_n)
        en && phase_reg == owb_pkg::PH_IDLE && item.command == owb_pkg::CMD_TICK
        |=> phase_reg == owb_pkg::PH_IDLE)
        else $error("idle tick left idle");

    a_reset_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        is_reset_reg |-> bit_index_reg == '0)
        else $error("bit index moved during bus reset");

    a_rx_stable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != owb_pkg::PH_IDLE && !done_now |-> rx_hold_next == rx_hold_reg)
        else $error("received byte changed mid exchange");
`endif

endmodule

FILE: rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps

// Channel   Signals                          Beat
// command   cmd_valid, cmd_stall, cmd_data   one tick: command, tx_byte, line_level
// result    res_valid, res_stall, res_data   one per tick: drive, busy, done, presence, rx
// config    wr_en, wr_index, wr_data         one register write per enabled edge
//
// One tick beat is taken every cycle unless cmd_stall holds it; its result beat appears
// in the next cycle from the result register.
// Bus timing is counted in tick beats, not clock cycles, by the phase counter.
// cmd_stall follows res_stall while a result beat is held in the register.
// Reset clears the phase state and loads the default timing registers.

module one_wire_bus_master (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  owb_pkg::owb_in_t            cmd_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output owb_pkg::owb_out_t           res_data,
    input  logic                        wr_en,
    input  logic [owb_pkg::IndexW-1:0]  wr_index,
    input  logic [owb_pkg::CountW-1:0]  wr_data
);

    owb_pkg::owb_cfg_t  cfg_reg;
    owb_pkg::owb_out_t  res_reg;
    owb_pkg::owb_out_t  res_next;
    logic               res_valid_reg;
    logic               accept;

    assign cmd_stall = res_valid_reg & res_stall;
    assign accept    = cmd_valid & ~cmd_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    owb_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .cfg   (cfg_reg),
        .item  (cmd_data),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= owb_pkg::RESET_LOW_INIT;
            cfg_reg.presence_wait_ticks <= owb_pkg::PRESENCE_WAIT_INIT;
            cfg_reg.reset_tail_ticks    <= owb_pkg::RESET_TAIL_INIT;
            cfg_reg.slot_low_ticks      <= owb_pkg::SLOT_LOW_INIT;
            cfg_reg.sample_wait_ticks   <= owb_pkg::SAMPLE_WAIT_INIT;
            cfg_reg.slot_tail_ticks     <= owb_pkg::SLOT_TAIL_INIT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                owb_pkg::REG_RESET_LOW:     cfg_reg.reset_low_ticks     <= wr_data;
                owb_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait_ticks <= wr_data;
                owb_pkg::REG_RESET_TAIL:    cfg_reg.reset_tail_ticks    <= wr_data;
                owb_pkg::REG_SLOT_LOW:      cfg_reg.slot_low_ticks      <= wr_data[7:0];
                owb_pkg::REG_SAMPLE_WAIT:   cfg_reg.sample_wait_ticks   <= wr_data[7:0];
                owb_pkg::REG_SLOT_TAIL:     cfg_reg.slot_tail_ticks     <= wr_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: tb/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

    localparam int HOLD_LEN = 300;
    localparam logic [owb_pkg::IndexW-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [owb_pkg::IndexW-1:0] SPARE_INDEX_B = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cmd_valid = 1'b0;
    logic                         cmd_stall;
    owb_pkg::owb_in_t             cmd_data = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    owb_pkg::owb_out_t            res_data;
    logic                         wr_en = 1'b0;
    logic [owb_pkg::IndexW-1:0]   wr_index = '0;
    logic [owb_pkg::CountW-1:0]   wr_data = '0;

    one_wire_bus_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bus master state as predicted
    owb_pkg::owb_cfg_t          timing;
    owb_pkg::phase_t            bus_phase;
    logic [owb_pkg::CountW-1:0] bus_count;
    logic [2:0]                 bit_no;
    logic [7:0]                 shift_reg;
    logic                       pres_flag;
    logic                       slot_rx;
    logic                       doing_reset;
    logic [7:0]                 rx_last;
    logic                       done_flag;

    owb_pkg::owb_in_t  ticks_pending[$];
    owb_pkg::owb_out_t bus_results_due[$];

    bit offering = 1'b0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int send_gap = 0;
    int send_quiet = 0;
    int recv_gap = 0;
    int recv_quiet = 0;
    bit hold_armed = 1'b0;
    int hold_cycles = 0;

    int failures = 0;
    int ticks_taken = 0;
    int results_seen = 0;
    int resets_done = 0;
    int bytes_done = 0;
    int stalled_in = 0;
    int settings_used = 0;

    function automatic int pause_len(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            quiet = $urandom_range(20, 120);
            return 0;
        end
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic logic [owb_pkg::CountW-1:0] count_from(
        input logic [owb_pkg::CountW-1:0] n);
        return (n == '0) ? '0 : n - 10'd1;
    endfunction

    function automatic void start_low();
        bus_phase = owb_pkg::PH_LOW;
        bus_count = count_from(doing_reset ? timing.reset_low_ticks
                                           : {2'b00, timing.slot_low_ticks});
    endfunction

    function automatic void close_slot();
        if (doing_reset)
        begin
            bus_phase = owb_pkg::PH_IDLE;
            done_flag = 1'b1;
            resets_done++;
        end
        else
        begin
            shift_reg = {slot_rx, shift_reg[7:1]};
            if (bit_no == owb_pkg::LAST_BIT)
            begin
                rx_last = shift_reg;
                bit_no = '0;
                bus_phase = owb_pkg::PH_IDLE;
                done_flag = 1'b1;
                bytes_done++;
            end
            else
            begin
                bit_no++;
                start_low();
            end
        end
    endfunction

    function automatic owb_pkg::owb_out_t step_bus(input owb_pkg::owb_in_t t);
        owb_pkg::owb_out_t          r;
        logic [owb_pkg::CountW-1:0] n;
        done_flag = 1'b0;
        case (bus_phase)
            owb_pkg::PH_IDLE:
            begin
                if (t.command == owb_pkg::CMD_RESET)
                begin
                    doing_reset = 1'b1;
                    start_low();
                end
                else if (t.command == owb_pkg::CMD_WRITE || t.command == owb_pkg::CMD_READ)
                begin
                    doing_reset = 1'b0;
                    shift_reg = (t.command == owb_pkg::CMD_WRITE) ? t.tx_byte
                                                                  : owb_pkg::READ_PATTERN;
                    bit_no = '0;
                    slot_rx = 1'b0;
                    start_low();
                end
            end
            owb_pkg::PH_LOW:
            begin
                if (bus_count == '0)
                begin
                    bus_phase = owb_pkg::PH_WAIT;
                    bus_count = count_from(doing_reset ? timing.presence_wait_ticks
                                                       : {2'b00, timing.sample_wait_ticks});
                end
                else
                    bus_count--;
            end
            owb_pkg::PH_WAIT:
            begin
                if (bus_count == '0)
                begin
                    if (doing_reset)
                    begin
                        pres_flag = !t.line_level;
                        n = timing.reset_tail_ticks;
                    end
                    else
                    begin
                        slot_rx = shift_reg[0] & t.line_level;
                        n = {2'b00, timing.slot_tail_ticks};
                    end
                    if (n == '0)
                        close_slot();
                    else
                    begin
                        bus_phase = owb_pkg::PH_TAIL;
                        bus_count = n - 10'd1;
                    end
                end
                else
                    bus_count--;
            end
            default:
            begin
                if (bus_count == '0)
                    close_slot();
                else
                    bus_count--;
            end
        endcase
        r.drive_low = (bus_phase == owb_pkg::PH_LOW)
                   || (bus_phase != owb_pkg::PH_IDLE && !doing_reset && !shift_reg[0]);
        r.busy_res  = (bus_phase != owb_pkg::PH_IDLE);
        r.done_res  = done_flag;
        r.presence  = pres_flag;
        r.rx_byte   = rx_last;
        return r;
    endfunction

    // driver: one tick beat at a time, held until taken
    always @(negedge clk)
    begin
        if (offering && in_taken)
        begin
            offering = 1'b0;
            in_taken = 1'b0;
        end
        if (!offering)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (ticks_pending.size() > 0)
            begin
                cmd_data <= ticks_pending.pop_front();
                offering = 1'b1;
                send_gap = pause_len(send_quiet);
            end
        end
        cmd_valid <= offering;
    end

    always @(negedge clk)
    begin
        if (hold_armed && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            out_taken = 1'b0;
            recv_gap = pause_len(recv_quiet);
        end
        res_stall <= (recv_gap > 0) || (hold_armed && hold_cycles < HOLD_LEN);
        if (recv_gap > 0)
            recv_gap--;
    end

    // monitor: predict on every taken tick, check every taken result
    always @(posedge clk)
    begin : monitor
        owb_pkg::owb_out_t want;
        if (rst_n)
        begin
            if (cmd_valid && cmd_stall)
                stalled_in++;
            if (cmd_valid && !cmd_stall)
            begin
                bus_results_due.push_back(step_bus(cmd_data));
                in_taken = 1'b1;
                ticks_taken++;
            end
            if (res_valid && !res_stall)
            begin
                out_taken = 1'b1;
                results_seen++;
                if (bus_results_due.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = bus_results_due.pop_front();
                    if (res_data.drive_low !== want.drive_low
                        || res_data.busy_res !== want.busy_res
                        || res_data.done_res !== want.done_res
                        || res_data.presence !== want.presence
                        || res_data.rx_byte !== want.rx_byte)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: mismatch, expected drive %0b busy %0b done %0b ",
                                      "presence %0b rx %02h, got drive %0b busy %0b done %0b ",
                                      "presence %0b rx %02h"}, $time,
                                     want.drive_low, want.busy_res, want.done_res,
                                     want.presence, want.rx_byte,
                                     res_data.drive_low, res_data.busy_res,
                                     res_data.done_res, res_data.presence, res_data.rx_byte);
                    end
                end
            end
        end
    end

    task automatic push_tick(input owb_pkg::cmd_t cmd, input logic [7:0] tx, input int level);
        owb_pkg::owb_in_t t;
        t.command = cmd;
        t.tx_byte = tx;
        t.line_level = (level < 0) ? 1'($urandom_range(0, 1)) : level[0];
        ticks_pending.push_back(t);
    endtask

    task automatic push_idle(input int n, input int level);
        for (int k = 0; k < n; k++)
            push_tick(owb_pkg::CMD_TICK, 8'($urandom_range(0, 255)), level);
    endtask

    task automatic set_reg(input logic [owb_pkg::IndexW-1:0] idx,
                           input logic [owb_pkg::CountW-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            owb_pkg::REG_RESET_LOW:     timing.reset_low_ticks = val;
            owb_pkg::REG_PRESENCE_WAIT: timing.presence_wait_ticks = val;
            owb_pkg::REG_RESET_TAIL:    timing.reset_tail_ticks = val;
            owb_pkg::REG_SLOT_LOW:      timing.slot_low_ticks = val[owb_pkg::SlotW-1:0];
            owb_pkg::REG_SAMPLE_WAIT:   timing.sample_wait_ticks = val[owb_pkg::SlotW-1:0];
            owb_pkg::REG_SLOT_TAIL:     timing.slot_tail_ticks = val[owb_pkg::SlotW-1:0];
            default:                    ;
        endcase
    endtask

    task automatic retime(input int rl, input int pw, input int rt,
                          input int sl, input int sw, input int st);
        set_reg(owb_pkg::REG_RESET_LOW, 10'(rl));
        set_reg(owb_pkg::REG_PRESENCE_WAIT, 10'(pw));
        set_reg(owb_pkg::REG_RESET_TAIL, 10'(rt));
        set_reg(owb_pkg::REG_SLOT_LOW, 10'(sl));
        set_reg(owb_pkg::REG_SAMPLE_WAIT, 10'(sw));
        set_reg(owb_pkg::REG_SLOT_TAIL, 10'(st));
        settings_used++;
    endtask

    // drain, then feed bare ticks until the bus operation has finished
    task automatic settle();
        do
        begin
            if (bus_phase != owb_pkg::PH_IDLE)
                push_idle(32, -1);
            while (ticks_pending.size() > 0 || offering || bus_results_due.size() > 0)
                @(posedge clk);
        end
        while (bus_phase != owb_pkg::PH_IDLE);
        repeat (4) @(posedge clk);
    endtask

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    initial
    begin
        int            left;
        int            span;
        owb_pkg::cmd_t op;

        timing.reset_low_ticks     = owb_pkg::RESET_LOW_INIT;
        timing.presence_wait_ticks = owb_pkg::PRESENCE_WAIT_INIT;
        timing.reset_tail_ticks    = owb_pkg::RESET_TAIL_INIT;
        timing.slot_low_ticks      = owb_pkg::SLOT_LOW_INIT;
        timing.sample_wait_ticks   = owb_pkg::SAMPLE_WAIT_INIT;
        timing.slot_tail_ticks     = owb_pkg::SLOT_TAIL_INIT;
        bus_phase   = owb_pkg::PH_IDLE;
        bus_count   = '0;
        bit_no      = '0;
        shift_reg   = '0;
        pres_flag   = 1'b0;
        slot_rx     = 1'b0;
        doing_reset = 1'b0;
        rx_last     = '0;
        done_flag   = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // power-on timing
        push_tick(owb_pkg::CMD_TICK, 8'hFF, 0);
        push_tick(owb_pkg::CMD_TICK, 8'h00, 1);
        push_tick(owb_pkg::CMD_WRITE, 8'hA5, -1);
        settle();

        // short timing, spare indexes ignored, slot registers masked
        retime(2, 3, 2, 1, 2, 1);
        set_reg(SPARE_INDEX_A, 10'h3FF);
        set_reg(SPARE_INDEX_B, 10'h000);
        set_reg(owb_pkg::REG_SLOT_LOW, 10'h302);
        push_tick(owb_pkg::CMD_WRITE, 8'h00, 1);
        push_idle(40, 1);
        settle();
        push_tick(owb_pkg::CMD_WRITE, 8'hFF, -1);
        settle();
        push_tick(owb_pkg::CMD_READ, 8'h00, 0);
        push_idle(50, 0);
        settle();
        push_tick(owb_pkg::CMD_RESET, 8'h00, 0);
        push_idle(8, 0);
        settle();
        push_tick(owb_pkg::CMD_RESET, 8'h00, 1);
        push_idle(8, 1);
        settle();
        push_tick(owb_pkg::CMD_WRITE, 8'h3C, -1);
        push_tick(owb_pkg::CMD_READ, 8'h00, -1);
        push_tick(owb_pkg::CMD_RESET, 8'h00, -1);
        push_tick(owb_pkg::CMD_WRITE, 8'hC3, -1);
        settle();

        // zero counts everywhere
        retime(0, 0, 0, 0, 0, 0);
        push_tick(owb_pkg::CMD_RESET, 8'h00, 0);
        push_tick(owb_pkg::CMD_TICK, 8'h00, 0);
        settle();
        push_tick(owb_pkg::CMD_WRITE, 8'h96, -1);
        settle();
        push_tick(owb_pkg::CMD_READ, 8'h00, -1);
        settle();

        // random traffic over several short settings
        for (int s = 0; s < 4; s++)
        begin
            retime($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 3));
            left = 50;
            while (left > 0)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    case ($urandom_range(0, 2))
                        0:       op = owb_pkg::CMD_RESET;
                        1:       op = owb_pkg::CMD_WRITE;
                        default: op = owb_pkg::CMD_READ;
                    endcase
                    push_tick(op, 8'($urandom_range(0, 255)), -1);
                    if (op == owb_pkg::CMD_RESET)
                        span = at_least_one(int'(timing.reset_low_ticks))
                             + at_least_one(int'(timing.presence_wait_ticks))
                             + int'(timing.reset_tail_ticks);
                    else
                        span = 8 * (at_least_one(int'(timing.slot_low_ticks))
                                  + at_least_one(int'(timing.sample_wait_ticks))
                                  + int'(timing.slot_tail_ticks) + 1);
                    span = span - 2 + $urandom_range(0, 4);
                    if (span < 0)
                        span = 0;
                    push_idle(span, -1);
                    left -= span + 1;
                end
                else
                begin
                    ticks_pending.push_back(owb_pkg::owb_in_t'(11'($urandom_range(0, 2047))));
                    left--;
                end
            end
            if (s == 0)
            begin
                @(posedge clk);
                hold_armed = 1'b1;
            end
            settle();
        end

        settle();
        if (bus_results_due.size() > 0)
        begin
            $display("%0d expected result beats never arrived", bus_results_due.size());
            failures += bus_results_due.size();
        end
        $display("covered %0d tick beats and %0d result beats over %0d timing settings",
                 ticks_taken, results_seen, settings_used + 1);
        $display("%0d bus resets, %0d byte exchanges, %0d cycles with tick input held back",
                 resets_done, bytes_done, stalled_in);
        if (failures == 0)
            $display("one_wire_bus_master regression: pass");
        else
            $display("one_wire_bus_master regression: fail");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("one_wire_bus_master regression: fail");
        $finish;
    end

endmodule
